// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int unsigned UNIT_TICKS_W  = 16;
  localparam int unsigned ACK_TIMEOUT_W = 8;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [UNIT_TICKS_W-1:0]  UNIT_TICKS_RST  = 16'd50;
  localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd50;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  // item kind
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // command codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_BUS  = 2'd1;
  localparam logic [1:0] ERR_NACK = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_START,
    CLS_STOP,
    CLS_WRITE,
    CLS_READ
  } item_cls_t;

  typedef struct packed {
    item_cls_t  cls;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } q_item_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_S_CHK1,
    PH_S_FALL,
    PH_S_CHK2,
    PH_S_HOLD,
    PH_P_A,
    PH_P_B,
    PH_P_C,
    PH_W_HI,
    PH_W_LO,
    PH_W_NEXT,
    PH_A_HI,
    PH_A_POLL,
    PH_R_HI,
    PH_R_SMP,
    PH_R_NEXT,
    PH_K_HI,
    PH_K_LO
  } phase_t;

endpackage

// ===== src/i2cm_front.sv =====
module i2cm_front (
  input  i2cm_pkg::in_item_t in_data,
  output i2cm_pkg::q_item_t  q_data
);
  import i2cm_pkg::*;

  item_cls_t cls;

  always_comb begin
    cls = CLS_TICK;
    if (in_data.kind == KIND_CMD) begin
      unique case (in_data.op)
        OP_START: cls = CLS_START;
        OP_STOP:  cls = CLS_STOP;
        OP_WRITE: cls = CLS_WRITE;
        OP_READ:  cls = CLS_READ;
        default:  cls = CLS_TICK;
      endcase
    end
  end

  assign q_data.cls      = cls;
  assign q_data.tx_byte  = in_data.tx_byte;
  assign q_data.send_ack = in_data.send_ack;
  assign q_data.sda_in   = in_data.sda_in;

endmodule

// ===== src/i2cm_queue.sv =====
module i2cm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  i2cm_pkg::q_item_t  wr_data,
  output logic               rd_valid,
  input  logic               rd_pop,
  output i2cm_pkg::q_item_t  rd_data
);
  import i2cm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !rd_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && rd_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/i2cm_back.sv =====
module i2cm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  i2cm_pkg::q_item_t                  q_data,
  output logic                               q_pop,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output i2cm_pkg::out_item_t                out_data
);
  import i2cm_pkg::*;

  logic [UNIT_TICKS_W-1:0]  unit_ticks_r;
  logic [ACK_TIMEOUT_W-1:0] ack_timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] unit_counter_r, unit_counter_nxt;
  logic [1:0]  units_left_r, units_left_nxt;
  logic [3:0]  bit_counter_r, bit_counter_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  ack_wait_r, ack_wait_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic [1:0]  last_error_r, last_error_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        is_tick, is_cmd, run, finish, unit_end, last_bit, timeout, sda_smp;
  logic [15:0] uc_inc;
  logic [1:0]  ul_dec;
  logic [3:0]  bc_inc;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_tick  = q_pop && (q_data.cls == CLS_TICK) && (phase_r != PH_IDLE);
  assign is_cmd   = q_pop && (q_data.cls != CLS_TICK) && (phase_r == PH_IDLE);
  assign sda_smp  = q_data.sda_in;
  assign uc_inc   = unit_counter_r + 16'd1;
  assign ul_dec   = units_left_r - 2'd1;
  assign unit_end = (uc_inc >= unit_ticks_r);
  // the step of a phase runs once its unit wait has fully elapsed
  assign run      = is_tick && ((units_left_r == 2'd0) || (unit_end && ul_dec == 2'd0));
  assign bc_inc   = bit_counter_r + 4'd1;
  assign last_bit = bc_inc[3];
  assign timeout  = (ack_wait_r >= ack_timeout_r);

  // phase and unit timing
  always_comb begin
    phase_nxt        = phase_r;
    units_left_nxt   = units_left_r;
    unit_counter_nxt = unit_counter_r;
    finish           = 1'b0;
    if (is_cmd) begin
      unit_counter_nxt = '0;
      unique case (q_data.cls)
        CLS_START: begin phase_nxt = PH_S_CHK1; units_left_nxt = 2'd0; end
        CLS_STOP:  begin phase_nxt = PH_P_A;    units_left_nxt = 2'd2; end
        CLS_WRITE: begin phase_nxt = PH_W_HI;   units_left_nxt = 2'd1; end
        CLS_READ:  begin phase_nxt = PH_R_HI;   units_left_nxt = 2'd1; end
        default: ;
      endcase
    end else if (is_tick) begin
      if (units_left_r != 2'd0) begin
        if (!unit_end) begin
          unit_counter_nxt = uc_inc;
        end else begin
          unit_counter_nxt = '0;
          units_left_nxt   = ul_dec;
        end
      end
      if (run) begin
        unit_counter_nxt = '0;
        unique case (phase_r)
          PH_S_CHK1: begin
            if (!sda_smp) finish = 1'b1;
            else begin phase_nxt = PH_S_FALL; units_left_nxt = 2'd1; end
          end
          PH_S_FALL: begin phase_nxt = PH_S_CHK2; units_left_nxt = 2'd0; end
          PH_S_CHK2: begin
            if (sda_smp) finish = 1'b1;
            else begin phase_nxt = PH_S_HOLD; units_left_nxt = 2'd2; end
          end
          PH_S_HOLD: finish = 1'b1;
          PH_P_A:    begin phase_nxt = PH_P_B; units_left_nxt = 2'd1; end
          PH_P_B:    begin phase_nxt = PH_P_C; units_left_nxt = 2'd2; end
          PH_P_C:    finish = 1'b1;
          PH_W_HI:   begin phase_nxt = PH_W_LO;   units_left_nxt = 2'd1; end
          PH_W_LO:   begin phase_nxt = PH_W_NEXT; units_left_nxt = 2'd1; end
          PH_W_NEXT: begin
            phase_nxt      = last_bit ? PH_A_HI : PH_W_HI;
            units_left_nxt = 2'd1;
          end
          PH_A_HI:   begin phase_nxt = PH_A_POLL; units_left_nxt = 2'd1; end
          PH_A_POLL: begin
            if (!sda_smp) finish = 1'b1;
            else if (timeout) begin phase_nxt = PH_P_A; units_left_nxt = 2'd2; end
            else begin phase_nxt = PH_A_POLL; units_left_nxt = 2'd1; end
          end
          PH_R_HI:   begin phase_nxt = PH_R_SMP;  units_left_nxt = 2'd1; end
          PH_R_SMP:  begin phase_nxt = PH_R_NEXT; units_left_nxt = 2'd1; end
          PH_R_NEXT: begin
            phase_nxt      = last_bit ? PH_K_HI : PH_R_HI;
            units_left_nxt = 2'd1;
          end
          PH_K_HI:   begin phase_nxt = PH_K_LO; units_left_nxt = 2'd1; end
          PH_K_LO:   finish = 1'b1;
          default:   finish = 1'b1;
        endcase
        if (finish) begin
          phase_nxt      = PH_IDLE;
          units_left_nxt = 2'd0;
        end
      end
    end
  end

  // bus levels and data path
  always_comb begin
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    shift_nxt      = shift_r;
    bit_counter_nxt = bit_counter_r;
    ack_wait_nxt   = ack_wait_r;
    ack_choice_nxt = ack_choice_r;
    last_error_nxt = last_error_r;
    rx_hold_nxt    = rx_hold_r;
    if (is_cmd) begin
      last_error_nxt = ERR_OK;
      unique case (q_data.cls)
        CLS_START: sda_nxt = 1'b1;
        CLS_STOP: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        CLS_WRITE: begin
          scl_nxt         = 1'b0;
          shift_nxt       = q_data.tx_byte;
          bit_counter_nxt = '0;
          sda_nxt         = q_data.tx_byte[7];
        end
        CLS_READ: begin
          scl_nxt         = 1'b0;
          sda_nxt         = 1'b1;
          shift_nxt       = '0;
          bit_counter_nxt = '0;
          ack_choice_nxt  = q_data.send_ack;
        end
        default: ;
      endcase
    end else if (run) begin
      unique case (phase_r)
        PH_S_CHK1: begin
          if (!sda_smp) last_error_nxt = ERR_BUS;
          else scl_nxt = 1'b1;
        end
        PH_S_FALL: sda_nxt = 1'b0;
        PH_S_CHK2: begin
          if (sda_smp) last_error_nxt = ERR_BUS;
        end
        PH_S_HOLD: scl_nxt = 1'b0;
        PH_P_A:    scl_nxt = 1'b1;
        PH_P_B:    sda_nxt = 1'b1;
        PH_W_HI:   scl_nxt = 1'b1;
        PH_W_LO:   scl_nxt = 1'b0;
        PH_W_NEXT: begin
          bit_counter_nxt = bc_inc;
          shift_nxt       = {shift_r[6:0], 1'b0};
          sda_nxt         = last_bit ? 1'b1 : shift_r[6];
        end
        PH_A_HI: begin
          scl_nxt      = 1'b1;
          ack_wait_nxt = '0;
        end
        PH_A_POLL: begin
          if (!sda_smp) begin
            scl_nxt = 1'b0;
          end else if (timeout) begin
            // no acknowledge: release the bus with a stop
            last_error_nxt = ERR_NACK;
            scl_nxt        = 1'b0;
            sda_nxt        = 1'b0;
          end else begin
            ack_wait_nxt = ack_wait_r + 8'd1;
          end
        end
        PH_R_HI:  scl_nxt = 1'b1;
        PH_R_SMP: shift_nxt = {shift_r[6:0], sda_smp};
        PH_R_NEXT: begin
          bit_counter_nxt = bc_inc;
          scl_nxt         = 1'b0;
          if (last_bit) sda_nxt = ~ack_choice_r;
        end
        PH_K_HI: scl_nxt = 1'b1;
        PH_K_LO: begin
          scl_nxt     = 1'b0;
          rx_hold_nxt = shift_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r  <= UNIT_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_UNIT_TICKS) begin
        unit_ticks_r <= cfg_data[UNIT_TICKS_W-1:0];
      end else if (cfg_index == CFG_ACK_TIMEOUT) begin
        ack_timeout_r <= cfg_data[ACK_TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      unit_counter_r <= '0;
      units_left_r   <= '0;
      bit_counter_r  <= '0;
      shift_r        <= '0;
      ack_wait_r     <= '0;
      scl_r          <= 1'b1;
      sda_r          <= 1'b1;
      ack_choice_r   <= 1'b0;
      last_error_r   <= ERR_OK;
      rx_hold_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      unit_counter_r <= unit_counter_nxt;
      units_left_r   <= units_left_nxt;
      bit_counter_r  <= bit_counter_nxt;
      shift_r        <= shift_nxt;
      ack_wait_r     <= ack_wait_nxt;
      scl_r          <= scl_nxt;
      sda_r          <= sda_nxt;
      ack_choice_r   <= ack_choice_nxt;
      last_error_r   <= last_error_nxt;
      rx_hold_r      <= rx_hold_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.scl_out    <= scl_nxt;
      out_data_r.sda_out    <= sda_nxt;
      out_data_r.busy_res   <= (phase_nxt != PH_IDLE);
      out_data_r.done_res   <= finish;
      out_data_r.rx_byte    <= rx_hold_nxt;
      out_data_r.error_code <= last_error_nxt;
    end
  end

endmodule

// ===== src/i2c_master_byte_controller.sv =====
// Path: an accepted item is held in a queue slot, then executed into the output
// register; it is held back only while out_ready is low.
// Throughput: one item per cycle while out_ready does not hold the output, bus phase timing is counted in tick items.
// Reset: synchronous, active low; bus lines released high, idle, queue empty,
// unit_ticks and ack_timeout back to 50.
module i2c_master_byte_controller #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  i2cm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output i2cm_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import i2cm_pkg::*;

  q_item_t cls_item;
  q_item_t q_head;
  logic    q_valid;
  logic    q_pop;

  i2cm_front u_front (
    .in_data (in_data),
    .q_data  (cls_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (cls_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_head)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/i2cm_checker.sv =====
module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_code == ERR_OK || out_data.error_code == ERR_BUS ||
                   out_data.error_code == ERR_NACK))
    else $error("invalid error code");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_master_byte_controller i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
